// File: hdl/pbdl_pkg.sv
package pbdl_pkg;

    // Fixed field widths
    localparam int unsigned CMD_W      = 3;
    localparam int unsigned BIDX_W     = 4;
    localparam int unsigned RAW_W      = 9;
    localparam int unsigned LIDX_W     = 3;
    localparam int unsigned LED_W      = 8;
    localparam int unsigned MS_W       = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    // Defaults and reset values
    localparam int unsigned BUTTONS_DEF  = 9;
    localparam int unsigned BUTTONS_MAX  = 16;
    localparam logic [MS_W-1:0]  DEBOUNCE_RST = 16'd50;
    localparam logic [MS_W-1:0]  SETTLE_RST   = 16'd0;
    localparam logic [LED_W-1:0] LED_RST      = 8'hE0;
    localparam logic [MS_W-1:0]  MS_MAX       = 16'hFFFF;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE   = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK     = 3'd0,
        CMD_LEVEL    = 3'd1,
        CMD_PRESSED  = 3'd2,
        CMD_RELEASED = 3'd3,
        CMD_SET_LED  = 3'd4,
        CMD_GET_LED  = 3'd5,
        CMD_ALIGN    = 3'd6
    } cmd_t;

endpackage

// File: hdl/pbdl_if.sv
interface pbdl_in_if;
    import pbdl_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BIDX_W-1:0] button_index;
    logic [RAW_W-1:0]  raw_buttons;
    logic [LIDX_W-1:0] led_index;
    logic              led_level;

    modport source (output valid, command, button_index, raw_buttons, led_index, led_level,
                    input ready);
    modport sink   (input valid, command, button_index, raw_buttons, led_index, led_level,
                    output ready);
endinterface

interface pbdl_out_if;
    import pbdl_pkg::*;

    logic             valid;
    logic             ready;
    logic             answer;
    logic [LED_W-1:0] led_pattern;
    logic             led_write;

    modport source (output valid, answer, led_pattern, led_write, input ready);
    modport sink   (input valid, answer, led_pattern, led_write, output ready);
endinterface

interface pbdl_cfg_if;
    import pbdl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/panel_button_debounce_led_latch_core.sv
// Panel button debounce and LED latch core.
//
// Channels: req carries one command per transfer (tick, button level/pressed/
// released query, set LED, get LED, align). rsp returns exactly one result
// per command: answer bit, current LED byte and a write strobe. cfg writes
// register 0 (debounce_ms) and register 1 (settle_offset_ms); it is always
// ready and must only be used while no command is in flight.
//
// Flow: a command accepted on req is held in the input register, then
// evaluated and moved into the result register once that slot is free,
// and its result shows on rsp from there.
// Throughput: one command per cycle while rsp takes results; all state
// (levels, latches, elapsed count, LED byte) updates in the single
// evaluation step between the two registers.
//
// Stall: when rsp is held off, the result register keeps its item and the
// input register absorbs one more command; req drops ready only when both
// are full.
// Reset: buttons released, no latches, elapsed count cleared, LED byte 0xE0,
// debounce 50 ticks, settle offset 0, both pipeline registers empty.
module panel_button_debounce_led_latch_core #(
    parameter int unsigned BUTTONS = pbdl_pkg::BUTTONS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    pbdl_cfg_if.sink    cfg,
    pbdl_in_if.sink     req,
    pbdl_out_if.source  rsp
);
    import pbdl_pkg::*;

    // Configuration registers
    logic [MS_W-1:0] debounce_reg;
    logic [MS_W-1:0] settle_reg;

    // Block state
    logic [BUTTONS-1:0] levels_reg, levels_next;
    logic [BUTTONS-1:0] press_reg, press_next;
    logic [BUTTONS-1:0] release_reg, release_next;
    logic [MS_W-1:0]    elapsed_reg, elapsed_next;
    logic [LED_W-1:0]   led_reg, led_next;

    // Input register
    logic              in_valid_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [BIDX_W-1:0] bidx_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [LIDX_W-1:0] lidx_reg;
    logic              level_reg;

    // Result register
    logic             out_valid_reg;
    logic             answer_reg, answer_next;
    logic             write_reg, write_next;

    logic advance;
    logic in_take;

    // Evaluation helpers
    logic [BUTTONS-1:0] fresh;
    logic [BUTTONS-1:0] bsel;
    logic               due;

    assign cfg.ready = 1'b1;

    // Move the held command into the result register whenever that slot frees
    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign in_take   = req.valid && req.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RST;
            settle_reg   <= SETTLE_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_DEBOUNCE: debounce_reg <= cfg.data;
                REG_SETTLE:   settle_reg   <= cfg.data;
                default:      ;
            endcase
        end
    end

    // Active-low pins, positions beyond the raw field read released
    for (genvar gi = 0; gi < BUTTONS; gi++)
    begin : g_pins
        if (gi < RAW_W)
        begin : g_live
            assign fresh[gi] = ~raw_reg[gi];
        end
        else
        begin : g_dead
            assign fresh[gi] = 1'b0;
        end
        // Out-of-range index selects nothing
        assign bsel[gi] = (bidx_reg == BIDX_W'(gi));
    end

    assign due = (elapsed_reg >= debounce_reg);

    always_comb
    begin
        levels_next  = levels_reg;
        press_next   = press_reg;
        release_next = release_reg;
        elapsed_next = elapsed_reg;
        led_next     = led_reg;
        answer_next  = 1'b0;
        write_next   = 1'b0;

        // Conditional sample ahead of every button query
        if ((cmd_reg == CMD_LEVEL || cmd_reg == CMD_PRESSED || cmd_reg == CMD_RELEASED)
            && due)
        begin
            if (fresh != levels_reg)
            begin
                press_next   = press_reg | ((fresh ^ levels_reg) & fresh);
                release_next = release_reg | ((fresh ^ levels_reg) & levels_reg);
                levels_next  = fresh;
                elapsed_next = '0;
            end
            else
            begin
                elapsed_next = settle_reg;
            end
        end

        case (cmd_reg)
            CMD_TICK:
            begin
                if (elapsed_reg != MS_MAX)
                    elapsed_next = elapsed_reg + 1'b1;
            end
            CMD_LEVEL:
            begin
                answer_next = |(levels_next & bsel);
            end
            CMD_PRESSED:
            begin
                answer_next = |(press_next & bsel);
                press_next  = press_next & ~bsel;
            end
            CMD_RELEASED:
            begin
                answer_next  = |(release_next & bsel);
                release_next = release_next & ~bsel;
            end
            CMD_SET_LED:
            begin
                // Inverted drive: level 0 sets the bit
                led_next[lidx_reg] = ~level_reg;
                write_next         = (led_next != led_reg);
            end
            CMD_GET_LED:
            begin
                answer_next = ~led_reg[lidx_reg];
            end
            CMD_ALIGN:
            begin
                levels_next  = fresh;
                elapsed_next = settle_reg;
                write_next   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            levels_reg    <= '0;
            press_reg     <= '0;
            release_reg   <= '0;
            elapsed_reg   <= SETTLE_RST;
            led_reg       <= LED_RST;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
            begin
                levels_reg    <= levels_next;
                press_reg     <= press_next;
                release_reg   <= release_next;
                elapsed_reg   <= elapsed_next;
                led_reg       <= led_next;
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg   <= req.command;
            bidx_reg  <= req.button_index;
            raw_reg   <= req.raw_buttons;
            lidx_reg  <= req.led_index;
            level_reg <= req.led_level;
        end
        if (advance)
        begin
            answer_reg <= answer_next;
            write_reg  <= write_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.answer      = answer_reg;
    assign rsp.led_pattern = led_reg;
    assign rsp.led_write   = write_reg;

endmodule

// File: hdl/pbdl_checker.sv
module pbdl_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic                      rsp_answer,
    input logic [pbdl_pkg::LED_W-1:0] rsp_led_pattern,
    input logic                      rsp_led_write
);
    import pbdl_pkg::*;

    logic             seen_reg;
    logic [LED_W-1:0] last_led_reg;

    // Track the LED byte of the last delivered result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            last_led_reg <= '0;
        end
        else if (rsp_valid && rsp_ready)
        begin
            seen_reg     <= 1'b1;
            last_led_reg <= rsp_led_pattern;
        end
    end

    a_led_change_strobes: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready && seen_reg && (rsp_led_pattern != last_led_reg)
        |-> rsp_led_write)
        else $error("LED byte changed without a write strobe");

    a_write_no_answer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_led_write |-> !rsp_answer)
        else $error("write strobe together with a set answer bit");

    a_result_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result appeared without a command transfer");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_led_pattern)
        && $stable(rsp_answer) && $stable(rsp_led_write))
        else $error("stalled result changed");

endmodule

bind panel_button_debounce_led_latch_core pbdl_checker u_pbdl_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_answer      (rsp.answer),
    .rsp_led_pattern (rsp.led_pattern),
    .rsp_led_write   (rsp.led_write)
);
